// File: rtl/door_stepper_half_step_driver_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the door stepper half-step driver
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOOR_STEPPER_HALF_STEP_DRIVER_CORE_ASSERT_SVH
`define DOOR_STEPPER_HALF_STEP_DRIVER_CORE_ASSERT_SVH

// Same-cycle implication
`define DSH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define DSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared types, constants and the half-step table for the door stepper driver.
// ----------------------------------------------------------------------------
package dsh_pkg;

    // Field widths
    localparam int unsigned ANGLE_W    = 9;
    localparam int unsigned TIMEOUT_W  = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned BEAT_W     = 13;
    localparam int unsigned MAG_W      = 12;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned COIL_W     = 4;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 8;
    localparam int unsigned ACT_W      = 2;

    // Motor geometry and register reset values
    localparam int unsigned STEPS_PER_REV = 4076;
    localparam int unsigned BEAT_MAX      = 4095;
    localparam int unsigned ANGLE_RESET   = 220;
    localparam int unsigned TIMEOUT_RESET = 60;

    // angle*STEPS_PER_REV/360 as one multiply by a rounded-up reciprocal.
    // With 18 fraction bits the error stays below 1/360 for any 9-bit angle.
    localparam int unsigned RECIP_SHIFT = 18;
    localparam int unsigned RECIP_W     = 22;
    localparam longint unsigned RECIP_MUL =
        ((longint'(STEPS_PER_REV) << RECIP_SHIFT) + 359) / 360;
    localparam int unsigned PROD_W      = ANGLE_W + RECIP_W;

    localparam int unsigned TRAVEL_RAW   = ANGLE_RESET * STEPS_PER_REV / 360;
    localparam int unsigned TRAVEL_RESET = (TRAVEL_RAW > BEAT_MAX) ? BEAT_MAX : TRAVEL_RAW;

    // Command codes carried on tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_OPEN  = 2'd1,
        ACT_CLOSE = 2'd2,
        ACT_CHECK = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DOOR_ANGLE    = 1'b0,
        REG_CLOSE_TIMEOUT = 1'b1
    } t_cfg_reg;

    // Settings seen by the update logic
    typedef struct packed {
        logic [MAG_W-1:0]     travel_mag;
        logic [TIMEOUT_W-1:0] close_timeout;
    } t_cfg;

    // Result beat, packed as on m_axis_tdata (coils in the low bits)
    typedef struct packed {
        logic              is_open;
        logic              busy;
        logic [COIL_W-1:0] coils;
    } t_result;

    // Half-step coil pattern
    function automatic logic [COIL_W-1:0] half_step_code(input logic [IDX_W-1:0] idx);
        logic [COIL_W-1:0] code;
        case (idx)
            3'd0:    code = 4'h1;
            3'd1:    code = 4'h3;
            3'd2:    code = 4'h2;
            3'd3:    code = 4'h6;
            3'd4:    code = 4'h4;
            3'd5:    code = 4'hc;
            3'd6:    code = 4'h8;
            default: code = 4'h9;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/dsh_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_cfg
// Configuration registers; the door angle is stored as its beat magnitude.
// ----------------------------------------------------------------------------
module dsh_cfg
    import dsh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    logic [MAG_W-1:0]     r_travel_mag;
    logic [TIMEOUT_W-1:0] r_close_timeout;

    logic [ANGLE_W-1:0]   w_angle;
    logic [PROD_W-1:0]    w_prod;
    logic [BEAT_W-1:0]    w_mag_full;
    logic [MAG_W-1:0]     n_travel_mag;

    // Beat magnitude from the written angle, saturated to 12 bits
    assign w_angle    = i_cfg_wdata[ANGLE_W-1:0];
    assign w_prod     = PROD_W'(w_angle) * PROD_W'(RECIP_MUL);
    assign w_mag_full = w_prod[RECIP_SHIFT +: BEAT_W];

    always_comb begin
        if (w_mag_full > BEAT_W'(BEAT_MAX)) begin
            n_travel_mag = MAG_W'(BEAT_MAX);
        end else begin
            n_travel_mag = w_mag_full[MAG_W-1:0];
        end
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_travel_mag    <= MAG_W'(TRAVEL_RESET);
            r_close_timeout <= TIMEOUT_W'(TIMEOUT_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_DOOR_ANGLE:    r_travel_mag    <= n_travel_mag;
                REG_CLOSE_TIMEOUT: r_close_timeout <= i_cfg_wdata[TIMEOUT_W-1:0];
                default:           ;
            endcase
        end
    end

    assign o_cfg.travel_mag    = r_travel_mag;
    assign o_cfg.close_timeout = r_close_timeout;

endmodule

// File: rtl/dsh_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_update
// Motor and door state, updated once per accepted input beat.
// ----------------------------------------------------------------------------
`include "door_stepper_half_step_driver_core_assert.svh"

module dsh_update
    import dsh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_action           i_action,
    input  logic [TIME_W-1:0] i_now_time,
    input  logic              i_standby,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    logic [IDX_W-1:0]         r_phase_index, n_phase_index;
    logic signed [BEAT_W-1:0] r_beats_left,  n_beats_left;
    logic                     r_busy,        n_busy;
    logic                     r_is_open,     n_is_open;
    logic [TIME_W-1:0]        r_open_ts,     n_open_ts;
    logic [COIL_W-1:0]        r_coils,       n_coils;

    logic [TIME_W-1:0]        w_deadline;
    logic                     w_timed_out;
    logic signed [BEAT_W-1:0] w_travel;
    logic signed [BEAT_W-1:0] w_beats_dec;
    logic                     w_fwd_tick;
    logic                     w_open_acc;

    // Auto-close deadline wraps modulo 2^32
    assign w_deadline  = r_open_ts + TIME_W'(i_cfg.close_timeout);
    assign w_timed_out = (i_now_time >= w_deadline);
    assign w_travel    = BEAT_W'(i_cfg.travel_mag);
    assign w_beats_dec = r_beats_left - BEAT_W'(1);

    // Next state for the current beat
    always_comb begin
        n_phase_index = r_phase_index;
        n_beats_left  = r_beats_left;
        n_busy        = r_busy;
        n_is_open     = r_is_open;
        n_open_ts     = r_open_ts;
        n_coils       = r_coils;
        unique case (i_action)
            ACT_TICK: begin
                if (r_beats_left != '0) begin
                    if (r_beats_left > 0) begin
                        n_phase_index = r_phase_index + IDX_W'(1);
                        n_beats_left  = w_beats_dec;
                    end else begin
                        n_phase_index = r_phase_index - IDX_W'(1);
                        n_beats_left  = r_beats_left + BEAT_W'(1);
                    end
                    n_coils = half_step_code(n_phase_index);
                end else if (r_busy) begin
                    n_coils = '0;
                    n_busy  = 1'b0;
                end
            end
            ACT_OPEN: begin
                n_is_open    = 1'b1;
                n_open_ts    = i_now_time;
                n_beats_left = -w_travel;
                n_busy       = 1'b1;
            end
            ACT_CLOSE: begin
                n_is_open    = 1'b0;
                n_beats_left = w_travel;
                n_busy       = 1'b1;
            end
            ACT_CHECK: begin
                if (i_standby && r_is_open && w_timed_out) begin
                    n_is_open    = 1'b0;
                    n_beats_left = w_travel;
                    n_busy       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_index <= '0;
            r_beats_left  <= '0;
            r_busy        <= 1'b0;
            r_is_open     <= 1'b0;
            r_open_ts     <= '0;
            r_coils       <= '0;
        end else if (i_accept) begin
            r_phase_index <= n_phase_index;
            r_beats_left  <= n_beats_left;
            r_busy        <= n_busy;
            r_is_open     <= n_is_open;
            r_open_ts     <= n_open_ts;
            r_coils       <= n_coils;
        end
    end

    // Result reflects the state after this beat
    assign o_result.coils   = n_coils;
    assign o_result.busy    = n_busy;
    assign o_result.is_open = n_is_open;

    // Accepted commands watched by the checks below
    assign w_fwd_tick = i_accept && (i_action == ACT_TICK) && (r_beats_left > 0);
    assign w_open_acc = i_accept && (i_action == ACT_OPEN);

    // A pending count always means a move is in progress
    `DSH_ASSERT_NOW(a_beats_imply_busy, !r_busy, r_beats_left == '0, "beats left while idle")
    // Forward tick counts down by one
    `DSH_ASSERT_NEXT(a_fwd_count, w_fwd_tick, r_beats_left == $past(w_beats_dec), "no count down")
    // Open command marks the door open
    `DSH_ASSERT_NEXT(a_open_marks_door, w_open_acc, r_is_open && r_busy, "open not recorded")

endmodule

// File: rtl/dsh_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_out
// Output register with a skid stage so input is taken while a result stalls.
// ----------------------------------------------------------------------------
`include "door_stepper_half_step_driver_core_assert.svh"

module dsh_out
    import dsh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_pop_ready,
    output t_result o_result
);

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out_data;
    t_result r_skid_data;
    logic    w_out_free;

    assign w_out_free = !r_out_vld || i_pop_ready;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld  <= r_skid_vld || i_push;
            r_skid_vld <= 1'b0;
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Payload; the skid beat is older than any new push
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_vld) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= i_result;
            end
        end else if (i_push) begin
            r_skid_data <= i_result;
        end
    end

    assign o_ready  = !r_skid_vld;
    assign o_valid  = r_out_vld;
    assign o_result = r_out_data;

    // Skid stage only fills behind a held output
    `DSH_ASSERT_NOW(a_skid_behind_out, r_skid_vld, r_out_vld, "skid full with output empty")

endmodule

// File: rtl/door_stepper_half_step_driver_core.sv
`timescale 1ns / 1ps
// State update and coil table lookup are combinational; the output stage registers results.
// Throughput: one beat per cycle while s_axis_tready is high.
// A two-entry output stage keeps s_axis_tready high while one result waits.
// Reset (synchronous, active low): motor idle, coils off, door closed,
// door angle 220 degrees, close timeout 60 seconds, output stage empty.
// ----------------------------------------------------------------------------
// door_stepper_half_step_driver_core
// Half-step sequencer for a four-coil door stepper with open, close,
// tick and standby auto-close commands.
// ----------------------------------------------------------------------------
module door_stepper_half_step_driver_core
    import dsh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Command stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // now_time[31:0], standby[32], zero pad
    input  logic [ACT_W-1:0]      s_axis_tuser,  // action[1:0]
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata   // coils[3:0], busy_res[4], is_open[5], zero pad
);

    t_cfg    w_cfg;
    t_result w_next_result;
    t_result w_out_result;
    logic    w_accept;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    dsh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    dsh_update u_update (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_action   (t_action'(s_axis_tuser)),
        .i_now_time (s_axis_tdata[TIME_W-1:0]),
        .i_standby  (s_axis_tdata[TIME_W]),
        .i_cfg      (w_cfg),
        .o_result   (w_next_result)
    );

    dsh_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_result    (w_next_result),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_result    (w_out_result)
    );

    assign m_axis_tdata = M_TDATA_W'(w_out_result);

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Door stepper half-step driver testbench
// Drives open, close, tick and auto-close check commands into the core and
// compares every status beat against a scripted value or a cycle-free model of the sequencer.
// A short scripted run at reset settings comes first. Several random phases
// follow, each with its own door angle and close timeout. Both streams idle
// at random, and the status side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    import dsh_pkg::*;

    // Coil patterns packed four bits per phase index, index 0 in the low nibble
    localparam logic [31:0] HALF_STEP_SEQ = 32'h98c4_6231;
    localparam int          HOLD_CYCLES   = 64;
    localparam int          SCRIPT_LEN    = 17;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // now_time[31:0], standby[32], zero pad
    logic [ACT_W-1:0]      s_axis_tuser;   // action[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // coils[3:0], busy_res[4], is_open[5], zero pad

    door_stepper_half_step_driver_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Door model state and settings
    logic [ANGLE_W-1:0]   door_angle_q;
    logic [TIMEOUT_W-1:0] close_timeout_q;
    logic [IDX_W-1:0]     phase_q;
    int                   beats_q;
    logic                 busy_q;
    logic                 open_q;
    logic [TIME_W-1:0]    open_time_q;
    logic [COIL_W-1:0]    coils_q;

    t_result expected_status[$];
    int      error_count;
    bit      quiet;        // no random idling on either side
    bit      hold_go;      // ask the status side for one long hold-off
    bit      hold_done;
    int      hold_left;
    logic [TIME_W-1:0] wall_clock;

    // Scripted commands at reset settings
    typedef struct packed {
        t_action           act;
        logic [TIME_W-1:0] now;
        logic              sb;
        logic              typed;
        t_result           res;
    } t_script_row;

    t_script_row door_script [SCRIPT_LEN];

    // Beat magnitude for the current angle, clipped to the count range
    function automatic int travel_beats();
        int unsigned mag;
        mag = door_angle_q;
        mag = mag * STEPS_PER_REV / 360;
        if (mag > BEAT_MAX)
            mag = BEAT_MAX;
        return int'(mag);
    endfunction

    task automatic start_close();
        beats_q = travel_beats();
        busy_q  = 1'b1;
        open_q  = 1'b0;
    endtask

    // Advance the door model by one command and return the status it reports
    task automatic step_door_model(input t_action act, input logic [TIME_W-1:0] now,
                                   input logic sb, output t_result res);
        logic [TIME_W-1:0] deadline;
        case (act)
            ACT_TICK: begin
                if (beats_q != 0) begin
                    if (beats_q > 0) begin
                        phase_q = phase_q + 3'd1;
                        beats_q = beats_q - 1;
                    end else begin
                        phase_q = phase_q - 3'd1;
                        beats_q = beats_q + 1;
                    end
                    coils_q = HALF_STEP_SEQ[phase_q*4 +: 4];
                end else if (busy_q) begin
                    coils_q = '0;
                    busy_q  = 1'b0;
                end
            end
            ACT_OPEN: begin
                open_q      = 1'b1;
                open_time_q = now;
                beats_q     = -travel_beats();
                busy_q      = 1'b1;
            end
            ACT_CLOSE: start_close();
            default: begin
                if (sb && open_q) begin
                    // deadline wraps modulo 2^32
                    deadline = open_time_q + {16'h0, close_timeout_q};
                    if (now >= deadline)
                        start_close();
                end
            end
        endcase
        res.coils   = coils_q;
        res.busy    = busy_q;
        res.is_open = open_q;
    endtask

    // Offer one command beat; the model advances when it is taken
    task automatic send_cmd(input t_action act, input logic [TIME_W-1:0] now, input logic sb,
                            input logic typed, input t_result typed_res);
        t_result pred;
        while (!quiet && $urandom_range(0, 99) < 15) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, sb, now};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        step_door_model(act, now, sb, pred);
        expected_status.push_back(typed ? typed_res : pred);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every status beat to come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_DOOR_ANGLE)
            door_angle_q = val[ANGLE_W-1:0];
        else
            close_timeout_q = val;
        @(negedge i_clk);
    endtask

    // One setting of the registers followed by random commands
    task automatic run_phase(input logic [ANGLE_W-1:0] angle, input logic [TIMEOUT_W-1:0] tmo,
                             input int count);
        int                r;
        t_action           act;
        logic [TIME_W-1:0] now;
        logic              sb;
        drain_results();
        write_reg(REG_DOOR_ANGLE, {7'b0, angle});
        write_reg(REG_CLOSE_TIMEOUT, tmo);
        wall_clock = $urandom;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            // mostly ticks while a move runs, so moves finish and coils release
            if (beats_q != 0) begin
                if (r < 92)      act = ACT_TICK;
                else if (r < 95) act = ACT_CHECK;
                else if (r < 98) act = ACT_OPEN;
                else             act = ACT_CLOSE;
            end else begin
                if (r < 40)      act = ACT_TICK;
                else if (r < 65) act = ACT_OPEN;
                else if (r < 85) act = ACT_CLOSE;
                else             act = ACT_CHECK;
            end
            if ($urandom_range(0, 9) == 0) begin
                now = $urandom;
            end else begin
                wall_clock = wall_clock + $urandom_range(0, 3);
                now = wall_clock;
            end
            sb = ($urandom_range(0, 3) != 0);
            send_cmd(act, now, sb, 1'b0, '0);
        end
    endtask

    // Status side: random stalls, one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_go && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 15);
        end
    end

    // Status checker
    always @(posedge i_clk) begin : status_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_status.size() == 0) begin
                $display("%0t: unexpected status beat %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                want = expected_status.pop_front();
                if (m_axis_tdata[3:0] !== want.coils) begin
                    $display("%0t: coils expected %h got %h", $time, want.coils,
                             m_axis_tdata[3:0]);
                    error_count++;
                end
                if (m_axis_tdata[4] !== want.busy) begin
                    $display("%0t: busy expected %b got %b", $time, want.busy, m_axis_tdata[4]);
                    error_count++;
                end
                if (m_axis_tdata[5] !== want.is_open) begin
                    $display("%0t: is_open expected %b got %b", $time, want.is_open,
                             m_axis_tdata[5]);
                    error_count++;
                end
            end
        end
    end

    // Run time limit
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_DOOR_ANGLE;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_TICK;
        error_count   = 0;
        quiet         = 1'b0;
        hold_go       = 1'b0;

        door_angle_q    = ANGLE_RESET;
        close_timeout_q = TIMEOUT_RESET;
        phase_q         = '0;
        beats_q         = 0;
        busy_q          = 1'b0;
        open_q          = 1'b0;
        open_time_q     = '0;
        coils_q         = '0;

        // res layout: is_open, busy, coils[3:0]
        door_script = '{
            '{ACT_TICK,  32'h0000_0000, 1'b0, 1'b1, 6'h00},  // idle tick after reset
            '{ACT_CHECK, 32'hffff_ffff, 1'b1, 1'b1, 6'h00},  // check with door closed
            '{ACT_CLOSE, 32'h0000_0000, 1'b0, 1'b1, 6'h10},  // close when already closed
            '{ACT_OPEN,  32'hffff_fff0, 1'b0, 1'b1, 6'h30},  // open keeps coils off
            '{ACT_TICK,  32'h0000_0000, 1'b0, 1'b0, 6'h00},
            '{ACT_TICK,  32'h0000_0000, 1'b1, 1'b0, 6'h00},
            '{ACT_OPEN,  32'hffff_fff0, 1'b1, 1'b0, 6'h00},  // open again mid-move
            '{ACT_CHECK, 32'h0000_002b, 1'b1, 1'b0, 6'h00},  // wrapped deadline not reached
            '{ACT_CHECK, 32'h0000_002c, 1'b0, 1'b0, 6'h00},  // not in standby
            '{ACT_CHECK, 32'h0000_002c, 1'b1, 1'b0, 6'h00},  // wrapped deadline reached
            '{ACT_TICK,  32'h0000_0000, 1'b0, 1'b0, 6'h00},
            '{ACT_CLOSE, 32'haaaa_aaaa, 1'b1, 1'b0, 6'h00},  // close again
            '{ACT_TICK,  32'h5555_5555, 1'b0, 1'b0, 6'h00},
            '{ACT_OPEN,  32'h0000_0000, 1'b0, 1'b0, 6'h00},
            '{ACT_CHECK, 32'h0000_003b, 1'b1, 1'b0, 6'h00},
            '{ACT_CHECK, 32'hffff_ffff, 1'b1, 1'b0, 6'h00},
            '{ACT_TICK,  32'hffff_ffff, 1'b1, 1'b0, 6'h00}
        };

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            send_cmd(door_script[i].act, door_script[i].now, door_script[i].sb,
                     door_script[i].typed, door_script[i].res);

        // zero angle: open loads no beats, next tick just releases
        run_phase(9'd0, 16'd0, 80);
        hold_go = 1'b1;
        run_phase(9'd2, 16'd5, 80);
        run_phase(9'd1, 16'hffff, 80);
        quiet = 1'b1;
        run_phase(9'd3, 16'd3, 80);
        quiet = 1'b0;
        run_phase(9'd360, 16'd10, 80);
        // beyond full travel the count clips
        run_phase(9'd511, 16'd0, 80);
        run_phase(9'd9, 16'd2, 80);
        run_phase(9'd4, 16'($urandom), 80);
        run_phase(9'($urandom_range(0, 12)), 16'($urandom_range(0, 30)), 80);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
